// ----- rtl/lru_dir_pkg.sv -----
// lru_dir_pkg: shared types, operation and status codes for the block cache directory
// no dependencies
package lru_dir_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned TAP_SPAN = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [2:0] {
    OP_GET        = 3'd0,
    OP_RELEASE    = 3'd1,
    OP_PIN        = 3'd2,
    OP_UNPIN      = 3'd3,
    OP_MARK_VALID = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_COUNT_ERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_OUT
  } state_t;

  // per-cell command from the controller
  typedef struct packed {
    logic             start;
    logic             apply;
    logic [2:0]       op;
    logic [7:0]       device;
    logic [31:0]      block;
    logic [31:0]      now;
    logic             do_alloc;
    logic             hit_sel;
  } cell_cmd_t;

  // candidate passed along the chain
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [31:0] best_time;
  } cand_t;

endpackage

// ----- rtl/lru_dir_cell.sv -----
// lru_dir_cell: one directory entry, compares its tag and folds its candidate into the chain
// depends on lru_dir_pkg
module lru_dir_cell
  import lru_dir_pkg::*;
#(
  parameter int unsigned IW = IDX_W,
  parameter logic [IW-1:0] MY_IDX = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_cmd_t     cmd,
  input  logic          sel,
  input  logic          cand_in_v,
  input  logic [IW-1:0] cand_in_idx,
  input  cand_t         cand_in,
  input  logic          hit_in_v,
  input  logic [IW-1:0] hit_in_idx,
  output logic          cand_out_v,
  output logic [IW-1:0] cand_out_idx,
  output cand_t         cand_out,
  output logic          hit_out_v,
  output logic [IW-1:0] hit_out_idx,
  output logic [CNT_W-1:0] count,
  output logic          dvalid
);

  logic             tag_r;
  logic [7:0]       dev_r;
  logic [31:0]      blk_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      time_r;
  logic             dv_r;
  logic             match;
  logic             take;

  assign match = tag_r && dev_r == cmd.device && blk_r == cmd.block;
  assign count = cnt_r;
  assign dvalid = dv_r;

  // chain folding: hit search picks lowest match, free search picks oldest lowest
  assign hit_out_v   = hit_in_v || match;
  assign hit_out_idx = hit_in_v ? hit_in_idx : MY_IDX;
  assign take = cnt_r == '0 && (!cand_in_v || time_r < cand_in.best_time);
  assign cand_out_v   = cand_in_v || take;
  assign cand_out_idx = take ? MY_IDX : cand_in_idx;
  assign cand_out.hit = 1'b0;
  assign cand_out.free = cand_in.free || take;
  assign cand_out.best_time = take ? time_r : cand_in.best_time;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.apply && sel) begin
      case (cmd.op) inside
        OP_GET: begin
          if (cmd.do_alloc) cnt_nxt = 8'd1;
          else if (cnt_r != COUNT_MAX) cnt_nxt = cnt_r + 8'd1;
        end
        OP_PIN: if (cnt_r != COUNT_MAX) cnt_nxt = cnt_r + 8'd1;
        OP_RELEASE, OP_UNPIN: if (cnt_r != '0) cnt_nxt = cnt_r - 8'd1;
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= 1'b0;
      dev_r  <= '0;
      blk_r  <= '0;
      cnt_r  <= '0;
      time_r <= '0;
      dv_r   <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.apply && sel) begin
        if (cmd.op == OP_GET && cmd.do_alloc) begin
          tag_r <= 1'b1;
          dev_r <= cmd.device;
          blk_r <= cmd.block;
          dv_r  <= 1'b0;
        end
        if (cmd.op == OP_RELEASE && cnt_r == 8'd1) time_r <= cmd.now;
        if (cmd.op == OP_MARK_VALID) dv_r <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lru_dir_chain.sv -----
// lru_dir_chain: row of directory cells with registered taps every eight cells
// depends on lru_dir_pkg, lru_dir_cell
module lru_dir_chain
  import lru_dir_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned IW = IDX_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] sel_idx,
  output logic          hit_v,
  output logic [IW-1:0] hit_idx,
  output logic          free_v,
  output logic [IW-1:0] free_idx,
  output logic [CNT_W-1:0] sel_count,
  output logic          sel_dvalid
);

  logic          cv_i [ENTRIES];
  logic [IW-1:0] ci_i [ENTRIES];
  cand_t         cc_i [ENTRIES];
  logic          hv_i [ENTRIES];
  logic [IW-1:0] hi_i [ENTRIES];
  logic          cv_o [ENTRIES];
  logic [IW-1:0] ci_o [ENTRIES];
  cand_t         cc_o [ENTRIES];
  logic          hv_o [ENTRIES];
  logic [IW-1:0] hi_o [ENTRIES];
  logic [CNT_W-1:0] cnt [ENTRIES];
  logic          dv  [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cv_i[g] = 1'b0;
      assign ci_i[g] = '0;
      assign cc_i[g] = '0;
      assign hv_i[g] = 1'b0;
      assign hi_i[g] = '0;
    end else if (g % TAP_SPAN == 0) begin : g_tap
      logic          tcv_r, thv_r;
      logic [IW-1:0] tci_r, thi_r;
      cand_t         tcc_r;
      always_ff @(posedge clk) begin
        tcv_r <= cv_o[g-1];
        tci_r <= ci_o[g-1];
        tcc_r <= cc_o[g-1];
        thv_r <= hv_o[g-1];
        thi_r <= hi_o[g-1];
      end
      assign cv_i[g] = tcv_r;
      assign ci_i[g] = tci_r;
      assign cc_i[g] = tcc_r;
      assign hv_i[g] = thv_r;
      assign hi_i[g] = thi_r;
    end else begin : g_link
      assign cv_i[g] = cv_o[g-1];
      assign ci_i[g] = ci_o[g-1];
      assign cc_i[g] = cc_o[g-1];
      assign hv_i[g] = hv_o[g-1];
      assign hi_i[g] = hi_o[g-1];
    end

    lru_dir_cell #(.IW(IW), .MY_IDX(IW'(g))) u_cell (
      .clk, .rst_n, .cmd,
      .sel(sel_idx == IW'(g)),
      .cand_in_v(cv_i[g]), .cand_in_idx(ci_i[g]), .cand_in(cc_i[g]),
      .hit_in_v(hv_i[g]), .hit_in_idx(hi_i[g]),
      .cand_out_v(cv_o[g]), .cand_out_idx(ci_o[g]), .cand_out(cc_o[g]),
      .hit_out_v(hv_o[g]), .hit_out_idx(hi_o[g]),
      .count(cnt[g]), .dvalid(dv[g])
    );
  end

  logic          hv_r, fv_r;
  logic [IW-1:0] hi_r, fi_r;

  always_ff @(posedge clk) begin
    hv_r <= hv_o[ENTRIES-1];
    hi_r <= hi_o[ENTRIES-1];
    fv_r <= cv_o[ENTRIES-1];
    fi_r <= ci_o[ENTRIES-1];
  end

  assign hit_v = hv_r;
  assign hit_idx = hi_r;
  assign free_v = fv_r;
  assign free_idx = fi_r;
  assign sel_count = cnt[sel_idx];
  assign sel_dvalid = dv[sel_idx];

endmodule

// ----- rtl/refcounted_lru_block_cache_directory_unit.sv -----
// Block cache directory top level: sequencing control and output register.
// depends on lru_dir_pkg, lru_dir_chain
// Usage: one request word enters on in_* (valid/ready); one result word leaves
// on out_* (valid/ready). A get compares the tag against every entry and runs
// an oldest-free search along the row of cells; the row is cut by a register
// every eight cells and both results are registered at its end. Then the
// selected entry is updated and the result word is registered.
// Order: after acceptance the scan state steps through the eight-cell segments
// of the row, then the apply state updates the entry, then out_valid is raised.
// A new word is taken only in the idle state, after the previous result has
// been accepted; the segmented scan, the apply state, the result state and the
// idle state in which the next word is taken all lie between two words.
// in_ready is low while a word is in flight and while a result waits.
// Reset (rst_n low, synchronous) clears all entries: tags, counts, times and
// data-valid marks go to zero and no result is pending.
// A stalled receiver holds the result word stable; no new word is taken until
// it is accepted.
module refcounted_lru_block_cache_directory_unit
  import lru_dir_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_operation,
  input  logic [7:0]       in_device,
  input  logic [31:0]      in_block_number,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [31:0]      in_current_time,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_result_entry,
  output logic             out_hit,
  output logic             out_needs_fill,
  output logic [1:0]       out_status
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NSEG = (ENTRIES + TAP_SPAN - 1) / TAP_SPAN;
  localparam int unsigned SC_W = $clog2(NSEG) + 1;

  state_t state_r, state_nxt;
  logic [2:0]  op_r;
  logic [7:0]  dev_r;
  logic [31:0] blk_r, now_r;
  logic [IDX_W-1:0] idx_r;
  logic [SC_W-1:0] scan_cnt_r;
  logic        scan_done;
  logic        inrange;
  logic [IDX_W-1:0] res_entry_r;
  logic        res_hit_r, res_fill_r;
  logic [1:0]  res_st_r;
  cell_cmd_t   cmd;
  logic [IW-1:0] sel_idx;
  logic        hit_v, free_v;
  logic [IW-1:0] hit_idx, free_idx;
  logic [CNT_W-1:0] sel_count;
  logic        sel_dvalid;
  logic        accept;

  assign accept = in_valid && in_ready;
  assign inrange = 32'(idx_r) < ENTRIES;
  assign scan_done = scan_cnt_r == SC_W'(NSEG - 1);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      dev_r <= in_device;
      blk_r <= in_block_number;
      idx_r <= in_entry_index;
      now_r <= in_current_time;
    end
  end

  // the scan counter advances through the segments of the cell row while in S_SCAN
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) scan_cnt_r <= scan_cnt_r + 1'b1;
    else scan_cnt_r <= '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (scan_done) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (op_r == OP_GET) sel_idx = hit_v ? hit_idx : free_idx;
    else sel_idx = IW'(idx_r);
    cmd.start    = state_r == S_SCAN;
    cmd.op       = op_r;
    cmd.device   = dev_r;
    cmd.block    = blk_r;
    cmd.now      = now_r;
    cmd.do_alloc = !hit_v;
    cmd.hit_sel  = hit_v;
    if (op_r == OP_GET) cmd.apply = state_r == S_APPLY && (hit_v || free_v);
    else cmd.apply = state_r == S_APPLY && inrange && op_r <= OP_MARK_VALID;
  end

  lru_dir_chain #(.ENTRIES(ENTRIES), .IW(IW)) u_chain (
    .clk, .rst_n, .cmd, .sel_idx,
    .hit_v, .hit_idx, .free_v, .free_idx,
    .sel_count, .sel_dvalid
  );

  always_ff @(posedge clk) begin
    if (state_r == S_APPLY) begin
      res_entry_r <= idx_r;
      res_hit_r   <= 1'b0;
      res_fill_r  <= 1'b0;
      res_st_r    <= ST_OK;
      if (op_r == OP_GET) begin
        if (hit_v) begin
          res_entry_r <= IDX_W'(hit_idx);
          res_hit_r   <= 1'b1;
          res_fill_r  <= !sel_dvalid;
          res_st_r    <= (sel_count == COUNT_MAX) ? ST_COUNT_ERR : ST_OK;
        end else if (free_v) begin
          res_entry_r <= IDX_W'(free_idx);
          res_fill_r  <= 1'b1;
        end else begin
          res_entry_r <= '0;
          res_st_r    <= ST_NO_FREE;
        end
      end else if (inrange && op_r <= OP_MARK_VALID) begin
        res_fill_r <= !(sel_dvalid || op_r == OP_MARK_VALID);
        case (op_r) inside
          OP_PIN: if (sel_count == COUNT_MAX) res_st_r <= ST_COUNT_ERR;
          OP_RELEASE, OP_UNPIN: if (sel_count == '0) res_st_r <= ST_COUNT_ERR;
          default: ;
        endcase
      end
    end
  end

  assign out_result_entry = res_entry_r;
  assign out_hit = res_hit_r;
  assign out_needs_fill = res_fill_r;
  assign out_status = res_st_r;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |=> out_valid) else $error("result not presented");
  a_hit_get_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> op_r == OP_GET) else $error("hit on non-get");
`endif

endmodule

// ----- tb/sv/refcounted_lru_block_cache_directory_unit_tb.sv -----
// testbench for the block cache directory: directed and random request words
// checked against an in-bench directory model; depends on lru_dir_pkg and the rtl
module refcounted_lru_block_cache_directory_unit_tb;
  import lru_dir_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 32;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [4:0] entry;
    logic       hit;
    logic       fill;
    logic [1:0] status;
  } dir_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_operation = '0;
  logic [7:0] in_device = '0;
  logic [31:0] in_block_number = '0;
  logic [4:0] in_entry_index = '0;
  logic [31:0] in_current_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] out_result_entry;
  logic out_hit;
  logic out_needs_fill;
  logic [1:0] out_status;

  refcounted_lru_block_cache_directory_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directory mirror
  logic        m_tag[NENT];
  logic [7:0]  m_dev[NENT];
  logic [31:0] m_blk[NENT];
  logic [7:0]  m_cnt[NENT];
  logic [31:0] m_time[NENT];
  logic        m_valid[NENT];

  dir_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit sink_idle = 1'b1;
  bit rx_stall_on = 1'b1;
  bit tx_gap_on = 1'b1;
  logic [31:0] tick = 32'd1;
  logic [7:0] recent_dev[$];
  logic [31:0] recent_blk[$];

  function automatic dir_result_t predict_directory(logic [2:0] op, logic [7:0] dev,
                                                    logic [31:0] blk, logic [4:0] idx,
                                                    logic [31:0] now);
    dir_result_t r;
    bit found;
    int pick;
    logic [31:0] best;
    r = '0;
    r.entry = idx;
    if (op == OP_GET) begin
      for (int i = 0; i < NENT; i++) begin
        if (m_tag[i] && m_dev[i] == dev && m_blk[i] == blk) begin
          r.entry = 5'(i);
          r.hit = 1'b1;
          r.fill = !m_valid[i];
          if (m_cnt[i] == COUNT_MAX) r.status = ST_COUNT_ERR;
          else m_cnt[i]++;
          return r;
        end
      end
      found = 0;
      pick = 0;
      best = '0;
      for (int i = 0; i < NENT; i++) begin
        if (m_cnt[i] == 0 && (!found || m_time[i] < best)) begin
          found = 1;
          pick = i;
          best = m_time[i];
        end
      end
      if (!found) begin
        r.entry = '0;
        r.status = ST_NO_FREE;
        return r;
      end
      m_tag[pick] = 1'b1;
      m_dev[pick] = dev;
      m_blk[pick] = blk;
      m_valid[pick] = 1'b0;
      m_cnt[pick] = 8'd1;
      r.entry = 5'(pick);
      r.fill = 1'b1;
      return r;
    end
    if (op > OP_MARK_VALID) return r;
    case (op)
      OP_RELEASE: begin
        if (m_cnt[idx] == 0) r.status = ST_COUNT_ERR;
        else begin
          m_cnt[idx]--;
          if (m_cnt[idx] == 0) m_time[idx] = now;
        end
      end
      OP_PIN: begin
        if (m_cnt[idx] == COUNT_MAX) r.status = ST_COUNT_ERR;
        else m_cnt[idx]++;
      end
      OP_UNPIN: begin
        if (m_cnt[idx] == 0) r.status = ST_COUNT_ERR;
        else m_cnt[idx]--;
      end
      default: m_valid[idx] = 1'b1;
    endcase
    r.fill = !m_valid[idx];
    return r;
  endfunction

  task automatic send_word(logic [2:0] op, logic [7:0] dev, logic [31:0] blk,
                           logic [4:0] idx, logic [31:0] now);
    int gap;
    if (tx_gap_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_device <= dev;
    in_block_number <= blk;
    in_entry_index <= idx;
    in_current_time <= now;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_directory(op, dev, blk, idx, now));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic get_block(logic [7:0] dev, logic [31:0] blk);
    send_word(OP_GET, dev, blk, 5'($urandom), $urandom);
    recent_dev.push_back(dev);
    recent_blk.push_back(blk);
    if (recent_dev.size() > 48) begin
      void'(recent_dev.pop_front());
      void'(recent_blk.pop_front());
    end
  endtask

  task automatic test_field_extremes();
    get_block(8'h00, 32'h0);
    get_block(8'hff, 32'hffff_ffff);
    get_block(8'h00, 32'h0);
    send_word(OP_MARK_VALID, 8'hff, 32'hffff_ffff, 5'd0, 32'h0);
    get_block(8'h00, 32'h0);
    send_word(OP_RELEASE, 8'h00, 32'h0, 5'd1, 32'hffff_ffff);
    send_word(OP_RELEASE, 8'h00, 32'h0, 5'd1, 32'h0);
    send_word(OP_UNPIN, 8'h00, 32'h0, 5'd31, 32'h0);
    send_word(OP_PIN, 8'h00, 32'h0, 5'd31, 32'h0);
    send_word(OP_UNPIN, 8'h00, 32'h0, 5'd31, 32'h0);
    send_word(OP_MARK_VALID, 8'h00, 32'h0, 5'd30, 32'h0);
    for (int op = 5; op < 8; op++) send_word(3'(op), 8'h5a, 32'h1234, 5'd7, 32'd9);
    drain_results();
  endtask

  task automatic test_count_saturation();
    get_block(8'h11, 32'h22);
    for (int i = 0; i < 256; i++) send_word(OP_PIN, 8'h0, 32'h0, 5'd2, 32'h0);
    get_block(8'h11, 32'h22);
    for (int i = 0; i < 256; i++) send_word(OP_RELEASE, 8'h0, 32'h0, 5'd2, 32'd77);
    drain_results();
  endtask

  task automatic test_no_free_entry();
    for (int i = 0; i < NENT + 2; i++) get_block(8'h40, 32'(i + 1000));
    for (int i = 0; i < NENT; i++)
      send_word(OP_RELEASE, 8'h0, 32'h0, 5'(i), 32'd100 - 32'(i % 4));
    get_block(8'h41, 32'd5);
    get_block(8'h41, 32'd6);
    drain_results();
  endtask

  task automatic test_random_traffic(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      tick = tick + $urandom_range(0, 3);
      k = $urandom_range(0, 99);
      if (k < 30) begin
        if (recent_dev.size() != 0 && $urandom_range(0, 1)) begin
          k = $urandom_range(0, recent_dev.size() - 1);
          get_block(recent_dev[k], recent_blk[k]);
        end else begin
          get_block(8'($urandom_range(0, 3)), $urandom_range(0, 60));
        end
      end else if (k < 32) begin
        get_block(8'($urandom), $urandom);
      end else if (k < 55) begin
        send_word(OP_RELEASE, 8'($urandom), $urandom, 5'($urandom), tick);
      end else if (k < 63) begin
        send_word(OP_RELEASE, 8'($urandom), $urandom, 5'($urandom), $urandom);
      end else if (k < 72) begin
        send_word(OP_PIN, 8'($urandom), $urandom, 5'($urandom), $urandom);
      end else if (k < 82) begin
        send_word(OP_UNPIN, 8'($urandom), $urandom, 5'($urandom), $urandom);
      end else if (k < 96) begin
        send_word(OP_MARK_VALID, 8'($urandom), $urandom, 5'($urandom), $urandom);
      end else begin
        send_word(3'($urandom_range(5, 7)), 8'($urandom), $urandom, 5'($urandom),
                  $urandom);
      end
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word entry %0d", out_result_entry);
      end else begin
        dir_result_t exp_r;
        exp_r = pending_results.pop_front();
        if (exp_r.entry !== out_result_entry || exp_r.hit !== out_hit ||
            exp_r.fill !== out_needs_fill || exp_r.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp entry %0d hit %0b fill %0b st %0d, got %0d %0b %0b %0d",
                     exp_r.entry, exp_r.hit, exp_r.fill, exp_r.status, out_result_entry,
                     out_hit, out_needs_fill, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rx_stall_on) out_ready <= 1'b1;
    else if (sink_idle) begin
      if ($urandom_range(0, 3) == 0) begin
        sink_idle = 1'b0;
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
        sink_idle = 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NENT; i++) begin
      m_tag[i] = 0; m_dev[i] = 0; m_blk[i] = 0;
      m_cnt[i] = 0; m_time[i] = 0; m_valid[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_count_saturation();
    test_no_free_entry();
    test_random_traffic(800);
    tx_gap_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random_traffic(300);
    $display("covered %0d result words: extremes, count saturation, full directory, random",
             results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
